### hw/rtl/spmq_pkg.sv
// Shared types and constants for the step pulse merge queue.
package spmq_pkg;

  // Field widths
  localparam int unsigned StampW  = 32;
  localparam int unsigned MaskW   = 2;
  localparam int unsigned StatusW = 3;

  // Default number of cells in the sorted chain
  localparam int unsigned DefDepth = 256;

  // Fan-in of one stage of the equal-match reduction tree
  localparam int unsigned FanLog = 4;
  localparam int unsigned FanIn  = 1 << FanLog;

  // Operation codes
  localparam logic OpInsert = 1'b0;
  localparam logic OpPop    = 1'b1;

  // Axis masks
  localparam logic [MaskW-1:0] MaskYaw   = 2'b01;
  localparam logic [MaskW-1:0] MaskPitch = 2'b10;

  // Result status codes
  localparam logic [StatusW-1:0] StPopped   = 3'd0;
  localparam logic [StatusW-1:0] StInserted = 3'd1;
  localparam logic [StatusW-1:0] StMerged   = 3'd2;
  localparam logic [StatusW-1:0] StEmpty    = 3'd3;
  localparam logic [StatusW-1:0] StFull     = 3'd4;

  // Command broadcast from the sequencer to every cell
  typedef struct packed {
    logic              cmp_en;    // latch compare flags against stamp
    logic              ins_en;    // open a slot and shift right
    logic              merge_en;  // OR pulse_bit into the equal cell
    logic              pop_en;    // shift left, dropping the head
    logic [StampW-1:0] stamp;
    logic [MaskW-1:0]  pulse_bit;
  } cell_cmd_t;

endpackage

### hw/rtl/spmq_cell.sv
// One slot of the sorted pulse chain: time, axis mask and compare flags.
module spmq_cell
  import spmq_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cell_cmd_t         cmd_i,
  input  logic              left_lt_i,
  input  logic [StampW-1:0] left_time_i,
  input  logic [MaskW-1:0]  left_mask_i,
  input  logic [StampW-1:0] right_time_i,
  input  logic [MaskW-1:0]  right_mask_i,
  output logic [StampW-1:0] time_o,
  output logic [MaskW-1:0]  mask_o,
  output logic              lt_o,
  output logic              eq_o
);

  logic [StampW-1:0] time_q, time_d;
  logic [MaskW-1:0]  mask_q, mask_d;
  logic              lt_q, eq_q;
  logic              valid;
  logic              time_we;

  // A live slot always carries at least one axis bit
  assign valid = |mask_q;

  // Slot update: merge, insert shift or pop shift
  always_comb begin
    time_d  = time_q;
    mask_d  = mask_q;
    time_we = 1'b0;
    if (cmd_i.merge_en && eq_q) begin
      mask_d = mask_q | cmd_i.pulse_bit;
    end else if (cmd_i.ins_en && !lt_q) begin
      time_we = 1'b1;
      if (left_lt_i) begin
        time_d = cmd_i.stamp;
        mask_d = cmd_i.pulse_bit;
      end else begin
        time_d = left_time_i;
        mask_d = left_mask_i;
      end
    end else if (cmd_i.pop_en) begin
      time_we = 1'b1;
      time_d  = right_time_i;
      mask_d  = right_mask_i;
    end
  end

  // Mask and flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
      lt_q   <= 1'b0;
      eq_q   <= 1'b0;
    end else begin
      mask_q <= mask_d;
      if (cmd_i.cmp_en) begin
        lt_q <= valid && (time_q < cmd_i.stamp);
        eq_q <= valid && (time_q == cmd_i.stamp);
      end
    end
  end

  // Stamp storage, no reset
  always_ff @(posedge clk_i) begin
    if (time_we) begin
      time_q <= time_d;
    end
  end

  assign time_o = time_q;
  assign mask_o = mask_q;
  assign lt_o   = lt_q;
  assign eq_o   = eq_q;

endmodule

### hw/rtl/spmq_or_tree.sv
// Registered OR reduction of the per-cell equal flags.
module spmq_or_tree
  import spmq_pkg::*;
#(
  parameter int unsigned N      = DefDepth,
  parameter int unsigned LEVELS = 2
) (
  input  logic         clk_i,
  input  logic [N-1:0] flag_i,
  output logic         any_o
);

  localparam int unsigned PadW = 1 << (FanLog * LEVELS);

  logic [PadW-1:0] src   [LEVELS];
  logic [PadW-1:0] lvl_d [LEVELS];
  logic [PadW-1:0] lvl_q [LEVELS];

  // Level k reads the padded flags or the previous level
  always_comb begin
    for (int k = 0; k < LEVELS; k++) begin
      if (k == 0) begin
        src[k] = PadW'(flag_i);
      end else begin
        src[k] = lvl_q[k-1];
      end
    end
  end

  // Each output bit ORs one group of FanIn inputs
  always_comb begin
    for (int k = 0; k < LEVELS; k++) begin
      lvl_d[k] = '0;
      for (int j = 0; j < PadW / FanIn; j++) begin
        lvl_d[k][j] = |src[k][FanIn*j +: FanIn];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < LEVELS; k++) begin
      lvl_q[k] <= lvl_d[k];
    end
  end

  assign any_o = lvl_q[LEVELS-1][0];

endmodule

### hw/rtl/step_pulse_merge_queue_unit.sv
// Top level: sorted step pulse queue built from a chain of cells.
//
// Input channel (in_valid_i / in_stall_o) carries op_i, axis_i and stamp_i.
// op_i = insert puts stamp_i for one axis into a time-sorted chain of DEPTH
// cells; a stamp already present gets the axis bit ORed into its mask.
// op_i = pop returns the earliest pulse and its axis mask and removes it.
// Output channel (out_valid_o / out_stall_i) gives one beat per input beat:
// pulse_stamp_o, pulse_mask_o and status_o (popped, inserted, merged, empty
// pop, full drop). Stamp and mask are zero on every beat that is not a pop.
// A beat is accepted when valid is high and stall is low.
// Each beat steps through these states, with LEVELS = ceil(log2(DEPTH) / 4)
// (2 at DEPTH 256): accept, a compare step in which every cell compares its
// stamp, LEVELS steps through the registered 16-way OR tree that finds an
// equal stamp, and an apply step in which all cells shift or merge.
// The result sits in an output register, so the next beat is taken while
// the result waits; a stalled result holds the chain update of the next beat.
// Reset clears all masks and the count, leaving the queue empty, and is
// usable as soon as it is released.
module step_pulse_merge_queue_unit
  import spmq_pkg::*;
#(
  parameter int unsigned DEPTH = DefDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               op_i,
  input  logic               axis_i,
  input  logic [StampW-1:0]  stamp_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [StampW-1:0]  pulse_stamp_o,
  output logic [MaskW-1:0]   pulse_mask_o,
  output logic [StatusW-1:0] status_o
);

  localparam int unsigned Levels = ($clog2(DEPTH) + FanLog - 1) / FanLog;
  localparam int unsigned RedW   = $clog2(Levels + 1);
  localparam int unsigned CntW   = $clog2(DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CMP   = 4'b0010,
    S_RED   = 4'b0100,
    S_APPLY = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [RedW-1:0]    red_cnt_q, red_cnt_d;
  logic [CntW-1:0]    count_q, count_d;
  logic               op_q;
  logic [MaskW-1:0]   bit_q;
  logic [StampW-1:0]  stamp_q;
  logic               out_valid_q, out_valid_d;
  logic [StampW-1:0]  out_stamp_q, out_stamp_d;
  logic [MaskW-1:0]   out_mask_q, out_mask_d;
  logic [StatusW-1:0] out_status_q, out_status_d;

  logic               in_accept;
  logic               out_free;
  logic               apply_go;
  logic               any_eq;
  logic               full;
  logic               empty;
  cell_cmd_t          cmd;

  logic [StampW-1:0]  cell_time [DEPTH];
  logic [MaskW-1:0]   cell_mask [DEPTH];
  logic [DEPTH-1:0]   cell_lt;
  logic [DEPTH-1:0]   cell_eq;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign apply_go   = (state_q == S_APPLY) && out_free;
  assign full       = (count_q == CntW'(DEPTH));
  assign empty      = (count_q == '0);

  // Command broadcast to the chain
  always_comb begin
    cmd.cmp_en    = (state_q == S_CMP);
    cmd.merge_en  = apply_go && (op_q == OpInsert) && any_eq;
    cmd.ins_en    = apply_go && (op_q == OpInsert) && !any_eq && !full;
    cmd.pop_en    = apply_go && (op_q == OpPop) && !empty;
    cmd.stamp     = stamp_q;
    cmd.pulse_bit = bit_q;
  end

  // Cell chain
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic              left_lt;
    logic [StampW-1:0] left_time;
    logic [MaskW-1:0]  left_mask;
    logic [StampW-1:0] right_time;
    logic [MaskW-1:0]  right_mask;

    if (i == 0) begin : g_head
      assign left_lt   = 1'b1;
      assign left_time = '0;
      assign left_mask = '0;
    end else begin : g_body
      assign left_lt   = cell_lt[i-1];
      assign left_time = cell_time[i-1];
      assign left_mask = cell_mask[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_time = '0;
      assign right_mask = '0;
    end else begin : g_mid
      assign right_time = cell_time[i+1];
      assign right_mask = cell_mask[i+1];
    end

    spmq_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cmd),
      .left_lt_i    (left_lt),
      .left_time_i  (left_time),
      .left_mask_i  (left_mask),
      .right_time_i (right_time),
      .right_mask_i (right_mask),
      .time_o       (cell_time[i]),
      .mask_o       (cell_mask[i]),
      .lt_o         (cell_lt[i]),
      .eq_o         (cell_eq[i])
    );
  end

  // Equal-stamp search over all cells
  spmq_or_tree #(
    .N      (DEPTH),
    .LEVELS (Levels)
  ) u_or_tree (
    .clk_i  (clk_i),
    .flag_i (cell_eq),
    .any_o  (any_eq)
  );

  // Sequencer
  always_comb begin
    state_d   = state_q;
    red_cnt_d = red_cnt_q;
    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        state_d   = S_RED;
        red_cnt_d = '0;
      end
      S_RED: begin
        if (red_cnt_q == RedW'(Levels - 1)) begin
          state_d = S_APPLY;
        end else begin
          red_cnt_d = red_cnt_q + 1'b1;
        end
      end
      S_APPLY: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Count and result
  always_comb begin
    count_d      = count_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_stamp_d  = out_stamp_q;
    out_mask_d   = out_mask_q;
    out_status_d = out_status_q;
    if (apply_go) begin
      out_valid_d = 1'b1;
      out_stamp_d = '0;
      out_mask_d  = '0;
      if (op_q == OpPop) begin
        if (empty) begin
          out_status_d = StEmpty;
        end else begin
          out_stamp_d  = cell_time[0];
          out_mask_d   = cell_mask[0];
          out_status_d = StPopped;
          count_d      = count_q - 1'b1;
        end
      end else if (any_eq) begin
        out_status_d = StMerged;
      end else if (full) begin
        out_status_d = StFull;
      end else begin
        out_status_d = StInserted;
        count_d      = count_q + 1'b1;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      red_cnt_q   <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      red_cnt_q   <= red_cnt_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Input beat and result payload
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q    <= op_i;
      bit_q   <= axis_i ? MaskPitch : MaskYaw;
      stamp_q <= stamp_i;
    end
    out_stamp_q  <= out_stamp_d;
    out_mask_q   <= out_mask_d;
    out_status_q <= out_status_d;
  end

  assign out_valid_o   = out_valid_q;
  assign pulse_stamp_o = out_stamp_q;
  assign pulse_mask_o  = out_mask_q;
  assign status_o      = out_status_q;

endmodule
